[hdl/hsv_pkg.sv]
`default_nettype none

package hsv_pkg;

  // Number of hue steps that make up one of the six colour regions.
  localparam logic [7:0] HUE_STEPS = 8'd43;
  localparam logic [7:0] FULL_SCALE = 8'd255;
  localparam int unsigned STAGES = 5;

  typedef enum logic [2:0] {
    REGION_0 = 3'd0,
    REGION_1 = 3'd1,
    REGION_2 = 3'd2,
    REGION_3 = 3'd3,
    REGION_4 = 3'd4,
    REGION_5 = 3'd5
  } region_t;

  typedef struct packed {
    region_t    region;
    logic [7:0] frac;
  } hue_split_t;

  // Truncating division by 255, exact for every product of two 8-bit values.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

endpackage

`default_nettype wire

[hdl/hsv_hue_split.sv]
`default_nettype none

module hsv_hue_split (
  input  wire logic [7:0]         hue,
  output hsv_pkg::hue_split_t     split
);

  logic [7:0] base;
  logic [7:0] rem;

  always_comb begin
    if (hue >= 8'(5 * hsv_pkg::HUE_STEPS)) begin
      split.region = hsv_pkg::REGION_5;
      base         = 8'(5 * hsv_pkg::HUE_STEPS);
    end else if (hue >= 8'(4 * hsv_pkg::HUE_STEPS)) begin
      split.region = hsv_pkg::REGION_4;
      base         = 8'(4 * hsv_pkg::HUE_STEPS);
    end else if (hue >= 8'(3 * hsv_pkg::HUE_STEPS)) begin
      split.region = hsv_pkg::REGION_3;
      base         = 8'(3 * hsv_pkg::HUE_STEPS);
    end else if (hue >= 8'(2 * hsv_pkg::HUE_STEPS)) begin
      split.region = hsv_pkg::REGION_2;
      base         = 8'(2 * hsv_pkg::HUE_STEPS);
    end else if (hue >= hsv_pkg::HUE_STEPS) begin
      split.region = hsv_pkg::REGION_1;
      base         = hsv_pkg::HUE_STEPS;
    end else begin
      split.region = hsv_pkg::REGION_0;
      base         = 8'd0;
    end
    rem = hue - base;
    // The remainder is at most 42, so six times it still fits in eight bits.
    split.frac = {rem[5:0], 2'b00} + {rem[6:0], 1'b0};
  end

endmodule

`default_nettype wire

[hdl/hsv_to_rgb_8bit_core.sv]
`default_nettype none

// Integer HSV to RGB conversion, one pixel per request.
//
// Input channel (in_*): one request carries hue, saturation and brightness,
// eight bits each. Output channel (out_*): one request carries red, green
// and blue, eight bits each. Every input request yields exactly one output
// request, in order.
//
// The datapath is a five-stage pipeline: hue split, three products, division
// by 255 of those, two products with the brightness, and a last division by
// 255 with the channel selection. A request accepted while in_tready is high
// reaches out_tvalid through each of the stage registers in turn; throughput
// is one pixel per clock while out_tready does not stall the pipeline, set by
// the pipeline of 8x8 multipliers and constant dividers.
//
// Each stage holds its own valid bit and advances when the stage after it
// has room, so a stalled receiver fills the pipeline up before in_tready
// drops; nothing is lost or repeated. A synchronous low rst_n empties the
// pipeline, and in_tready is high in the cycle after reset.
module hsv_to_rgb_8bit_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // hue[7:0], saturation[15:8], brightness[23:16]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // red[7:0], green[15:8], blue[23:16]
);

  logic [hsv_pkg::STAGES-1:0] valid_r;
  logic [hsv_pkg::STAGES-1:0] valid_nxt;
  logic [hsv_pkg::STAGES-1:0] adv;

  hsv_pkg::hue_split_t split;

  // Stage 1: hue split.
  hsv_pkg::region_t region1_r;
  logic [7:0]       frac1_r, sat1_r, val1_r;
  // Stage 2: products with the saturation.
  hsv_pkg::region_t region2_r;
  logic [15:0]      sf2_r, sg2_r, pv2_r;
  logic [7:0]       val2_r;
  // Stage 3: scaled factors and p.
  hsv_pkg::region_t region3_r;
  logic [7:0]       kq3_r, kt3_r, p3_r, val3_r;
  // Stage 4: products with the brightness.
  hsv_pkg::region_t region4_r;
  logic [15:0]      qv4_r, tv4_r;
  logic [7:0]       p4_r, val4_r;
  // Stage 5: result.
  logic [7:0]       red_r, green_r, blue_r;
  logic [7:0]       red_nxt, green_nxt, blue_nxt;
  logic [7:0]       q4, t4;

  always_comb begin
    adv[hsv_pkg::STAGES-1] = !valid_r[hsv_pkg::STAGES-1] || out_tready;
    for (int i = hsv_pkg::STAGES - 2; i >= 0; i--) begin
      adv[i] = !valid_r[i] || adv[i+1];
    end
    valid_nxt[0] = adv[0] ? in_tvalid : valid_r[0];
    for (int i = 1; i < hsv_pkg::STAGES; i++) begin
      if (adv[i]) begin
        valid_nxt[i] = valid_r[i-1];
      end else begin
        valid_nxt[i] = valid_r[i];
      end
    end
  end

  assign in_tready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  hsv_hue_split u_split (
    .hue   (in_tdata[7:0]),
    .split (split)
  );

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      region1_r <= split.region;
      frac1_r   <= split.frac;
      sat1_r    <= in_tdata[15:8];
      val1_r    <= in_tdata[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      region2_r <= region1_r;
      sf2_r     <= 16'(sat1_r) * 16'(frac1_r);
      sg2_r     <= 16'(sat1_r) * 16'(hsv_pkg::FULL_SCALE - frac1_r);
      pv2_r     <= 16'(val1_r) * 16'(hsv_pkg::FULL_SCALE - sat1_r);
      val2_r    <= val1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      region3_r <= region2_r;
      kq3_r     <= hsv_pkg::FULL_SCALE - hsv_pkg::div255(sf2_r);
      kt3_r     <= hsv_pkg::FULL_SCALE - hsv_pkg::div255(sg2_r);
      p3_r      <= hsv_pkg::div255(pv2_r);
      val3_r    <= val2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      region4_r <= region3_r;
      qv4_r     <= 16'(val3_r) * 16'(kq3_r);
      tv4_r     <= 16'(val3_r) * 16'(kt3_r);
      p4_r      <= p3_r;
      val4_r    <= val3_r;
    end
  end

  // Zero saturation needs no separate path: p, q and t all reduce to the
  // brightness exactly, which gives grey in every region.
  always_comb begin
    q4 = hsv_pkg::div255(qv4_r);
    t4 = hsv_pkg::div255(tv4_r);
    case (region4_r)
      hsv_pkg::REGION_0: begin
        red_nxt = val4_r; green_nxt = t4;     blue_nxt = p4_r;
      end
      hsv_pkg::REGION_1: begin
        red_nxt = q4;     green_nxt = val4_r; blue_nxt = p4_r;
      end
      hsv_pkg::REGION_2: begin
        red_nxt = p4_r;   green_nxt = val4_r; blue_nxt = t4;
      end
      hsv_pkg::REGION_3: begin
        red_nxt = p4_r;   green_nxt = q4;     blue_nxt = val4_r;
      end
      hsv_pkg::REGION_4: begin
        red_nxt = t4;     green_nxt = p4_r;   blue_nxt = val4_r;
      end
      default: begin
        red_nxt = val4_r; green_nxt = p4_r;   blue_nxt = q4;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_tvalid = valid_r[hsv_pkg::STAGES-1];
  assign out_tdata  = {blue_r, green_r, red_r};

endmodule

`default_nettype wire

[hdl/hsv_to_rgb_8bit_checker.sv]
`default_nettype none

module hsv_to_rgb_8bit_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [23:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  // No result can leave sooner than the full pipeline depth after reset.
  a_reset_drains: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid ##1 !out_tvalid ##1 !out_tvalid ##1 !out_tvalid
               ##1 !out_tvalid)
    else $error("result appeared before the pipeline depth after reset");

  // An empty pipeline always takes a request.
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // A waiting input request stays offered with the same data.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input request changed while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output data changed while stalled");

endmodule

bind hsv_to_rgb_8bit_core hsv_to_rgb_8bit_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

[tb/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] brightness;
    logic [7:0] saturation;
    logic [7:0] hue;
  } hsv_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // hue[7:0], saturation[15:8], brightness[23:16]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // red[7:0], green[15:8], blue[23:16]

  rgb_t        rgb_expected[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        rx_hold = 1'b0;

  hsv_to_rgb_8bit_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rgb_t hsv_to_rgb(input hsv_t px);
    int unsigned      h;
    int unsigned      s;
    int unsigned      v;
    int unsigned      f;
    int unsigned      p;
    int unsigned      q;
    int unsigned      t;
    hsv_pkg::region_t region;
    rgb_t             c;
    h = px.hue;
    s = px.saturation;
    v = px.brightness;
    if (s == 0) begin
      c.red   = v[7:0];
      c.green = v[7:0];
      c.blue  = v[7:0];
    end else begin
      region = hsv_pkg::region_t'(h / hsv_pkg::HUE_STEPS);
      f = (h - int'(region) * hsv_pkg::HUE_STEPS) * 6;
      p = v * (hsv_pkg::FULL_SCALE - s) / hsv_pkg::FULL_SCALE;
      q = v * (hsv_pkg::FULL_SCALE - s * f / hsv_pkg::FULL_SCALE)
          / hsv_pkg::FULL_SCALE;
      t = v * (hsv_pkg::FULL_SCALE - s * (hsv_pkg::FULL_SCALE - f) / hsv_pkg::FULL_SCALE)
          / hsv_pkg::FULL_SCALE;
      case (region)
        hsv_pkg::REGION_0: begin c.red = v[7:0]; c.green = t[7:0]; c.blue = p[7:0]; end
        hsv_pkg::REGION_1: begin c.red = q[7:0]; c.green = v[7:0]; c.blue = p[7:0]; end
        hsv_pkg::REGION_2: begin c.red = p[7:0]; c.green = v[7:0]; c.blue = t[7:0]; end
        hsv_pkg::REGION_3: begin c.red = p[7:0]; c.green = q[7:0]; c.blue = v[7:0]; end
        hsv_pkg::REGION_4: begin c.red = t[7:0]; c.green = p[7:0]; c.blue = v[7:0]; end
        default:           begin c.red = v[7:0]; c.green = p[7:0]; c.blue = q[7:0]; end
      endcase
    end
    return c;
  endfunction

  // Inputs and outputs are sampled at the clock edge, before any update lands.
  always @(posedge clk) begin : scoreboard
    rgb_t got;
    rgb_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (rgb_expected.size() == 0) begin
        $error("unexpected output request: %h", got);
        mismatches++;
      end else begin
        want = rgb_expected.pop_front();
        if (got.red !== want.red) begin
          $error("red: expected %0d, actual %0d", want.red, got.red);
          mismatches++;
        end
        if (got.green !== want.green) begin
          $error("green: expected %0d, actual %0d", want.green, got.green);
          mismatches++;
        end
        if (got.blue !== want.blue) begin
          $error("blue: expected %0d, actual %0d", want.blue, got.blue);
          mismatches++;
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      rgb_expected.push_back(hsv_to_rgb(hsv_t'(in_tdata)));
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // Called just after a rising edge; returns just after the edge that accepts the request.
  task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat,
                            input logic [7:0] bri);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {bri, sat, hue};
    do @(posedge clk); while (!in_tready);
  endtask

  // The first edge lets the scoreboard record the request accepted just before.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (rgb_expected.size() != 0) @(posedge clk);
  endtask

  function automatic hsv_t random_pixel();
    hsv_t px;
    int unsigned k;
    px = hsv_t'(24'($urandom()));
    case ($urandom_range(9))
      0: px.saturation = 8'd0;
      1: px.saturation = 8'd255;
      2: px.brightness = 8'd255;
      3: begin
        // Land on either side of a region boundary.
        k = $urandom_range(5);
        px.hue = 8'(k * hsv_pkg::HUE_STEPS + ($urandom_range(1) ? 0 : 42));
      end
      4: px.hue = 8'($urandom_range(255, 215));
      default: ;
    endcase
    return px;
  endfunction

  task automatic test_directed();
    logic [7:0] edge_hues[14];
    edge_hues = '{8'd0, 8'd1, 8'd42, 8'd43, 8'd85, 8'd86, 8'd128, 8'd129,
                  8'd171, 8'd172, 8'd214, 8'd215, 8'd254, 8'd255};
    set_idling(0, 0);
    foreach (edge_hues[i]) send_pixel(edge_hues[i], 8'd255, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd100, 8'd0, 8'd255);
    send_pixel(8'd230, 8'd0, 8'd128);
    send_pixel(8'd60, 8'd1, 8'd255);
    send_pixel(8'd150, 8'd255, 8'd0);
    send_pixel(8'd20, 8'd128, 8'd200);
    send_pixel(8'd240, 8'd200, 8'd1);
    send_pixel(8'd170, 8'd127, 8'd254);
    wait_drained();
  endtask

  task automatic test_random(input int unsigned count, input int unsigned send_pct,
                             input int unsigned recv_pct);
    hsv_t px;
    set_idling(send_pct, recv_pct);
    repeat (count) begin
      px = random_pixel();
      send_pixel(px.hue, px.saturation, px.brightness);
    end
    wait_drained();
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall the input.
  task automatic test_backpressure();
    hsv_t px;
    set_idling(0, 0);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (60) begin
      px = random_pixel();
      send_pixel(px.hue, px.saturation, px.brightness);
    end
    wait_drained();
  endtask

  // The sender stops until every result is out, then resumes.
  task automatic test_sender_pause();
    hsv_t px;
    set_idling(0, 37);
    repeat (4) begin
      repeat (10) begin
        px = random_pixel();
        send_pixel(px.hue, px.saturation, px.brightness);
      end
      wait_drained();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(400, 0, 0);
    test_random(400, 79, 0);
    test_random(400, 0, 79);
    test_random(300, 37, 37);
    test_backpressure();
    test_sender_pause();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && rgb_expected.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/hsv_pkg.sv
hdl/hsv_hue_split.sv
hdl/hsv_to_rgb_8bit_core.sv
hdl/hsv_to_rgb_8bit_checker.sv
tb/tb_top.sv
